>>> src/htq_pkg.sv
// htq_pkg: shared constants and the queue entry type of the heightfield
// triangle height query core. Used by the front, queue, back and top files.
// No dependencies.
package htq_pkg;

    localparam int GRID_VERTS_DEF = 21;

    // one cell is 5.0 in Q8.8
    localparam int CELL_Q      = 1280;
    localparam int HALF_CELL_Q = 640;

    localparam int H_W = 16;   // height / coordinate width
    localparam int A_W = 13;   // x offset from the corner vertex, -2559..-1
    localparam int B_W = 12;   // z offset from the corner vertex, -1279..1279
    localparam int D_W = 17;   // height difference
    localparam int P_W = 30;   // offset times difference
    localparam int Y_W = 24;   // biased quotient numerator, always positive
    localparam int Q_W = 22;   // unsigned quotient of the divide by five

    // floor(y/5) for y < 2^24: (y * floor(2^27/5)) >> 27 is low by at most one
    localparam int DIV5_SHIFT = 27;
    localparam int DIV5_MUL_W = 25;
    localparam logic [DIV5_MUL_W-1:0] DIV5_MUL = 25'd26843545;
    localparam logic [Y_W-1:0] Y_OFF = 24'd10485760;   // 5 * 2^21
    localparam logic [Y_W-1:0] DIV5_MIN_REM = 24'd5;
    localparam int Q_OFF = 2097152;                       // 2^21

    localparam logic signed [H_W-1:0] SAT_MAX = 16'sh7fff;
    localparam logic signed [H_W-1:0] SAT_MIN = 16'sh8000;

    localparam int QUEUE_DEPTH = 4;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic                  is_load;
        logic                  outside;
        logic signed [H_W-1:0] height;
        logic signed [A_W-1:0] a;
        logic signed [B_W-1:0] b;
    } t_ent;

endpackage

>>> src/htq_ram.sv
// htq_ram: generic simple dual port RAM, one write and one registered read.
// Depends on nothing.
module htq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 121,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/htq_front.sv
// htq_front: input stage of the height query core. Registers each item, finds
// the grid cell and corner offsets of queries and pushes work to the queue.
// Depends on htq_pkg.
module htq_front #(
    parameter int GRID_VERTS = htq_pkg::GRID_VERTS_DEF,
    localparam int IDX_W = $clog2(GRID_VERTS)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [63:0]        i_s_tdata,
    input  logic               i_s_tuser,
    input  logic               i_q_full,
    output logic               o_q_push,
    output htq_pkg::t_ent      o_ent,
    output logic [IDX_W-1:0]   o_col,
    output logic [IDX_W-1:0]   o_row
);

    localparam int CENTER  = (GRID_VERTS - 1) / 2;
    localparam int S_W     = $clog2(CENTER * htq_pkg::CELL_Q + 32769) + 1;
    localparam int U_W     = S_W - 9;
    localparam int DIV_K   = U_W + 2;
    localparam int DIV_M   = ((1 << DIV_K) + 4) / 5;
    localparam int PROD_W  = U_W + DIV_K;
    localparam logic signed [S_W-1:0] S_CENTER   = S_W'(CENTER * htq_pkg::CELL_Q);
    localparam logic signed [S_W-1:0] S_NEG_CELL = S_W'(-htq_pkg::CELL_Q);

    // input fields
    logic                        w_take;
    logic [4:0]                  w_col_in;
    logic [4:0]                  w_row_in;
    logic signed [15:0]          w_qx;
    logic signed [15:0]          w_qz;

    logic                        r_vld;
    logic                        r_load;
    logic                        r_ok;
    logic [4:0]                  r_col_in;
    logic [4:0]                  r_row_in;
    logic [15:0]                 r_height;
    logic signed [S_W-1:0]       r_s;
    logic signed [S_W-1:0]       r_t;

    logic                        w_drop;
    logic                        w_fwd;
    logic signed [S_W-1:0]       w_crd      [2];
    logic [U_W-1:0]              w_u        [2];
    logic [PROD_W-1:0]           w_prod     [2];
    logic [U_W-1:0]              w_qt       [2];
    logic [U_W-1:0]              w_rem_full [2];
    logic signed [11:0]          w_low      [2];
    logic                        w_out      [2];
    logic [IDX_W-1:0]            w_idx      [2];

    assign w_col_in = i_s_tdata[4:0];
    assign w_row_in = i_s_tdata[9:5];
    assign w_qx     = i_s_tdata[41:26];
    assign w_qz     = i_s_tdata[57:42];

    assign w_drop     = r_load && !r_ok;
    assign w_fwd      = r_vld && (w_drop || !i_q_full);
    assign o_s_tready = !r_vld || w_fwd;
    assign w_take     = i_s_tvalid && o_s_tready;
    assign o_q_push   = r_vld && !w_drop && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_load   <= (i_s_tuser == htq_pkg::REQ_LOAD);
            r_ok     <= (int'(w_col_in) < GRID_VERTS) && (int'(w_row_in) < GRID_VERTS);
            r_col_in <= w_col_in;
            r_row_in <= w_row_in;
            r_height <= i_s_tdata[25:10];
            r_s      <= S_W'(w_qx) + S_CENTER;
            r_t      <= S_CENTER - S_W'(w_qz);
        end
    end

    assign w_crd[0] = r_s;
    assign w_crd[1] = r_t;

    // cell index per axis: truncate toward zero, divide by 1280 as >>8 then /5
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            w_u[k]        = w_crd[k][S_W-2:8];
            w_prod[k]     = PROD_W'(w_u[k]) * PROD_W'(DIV_M);
            w_qt[k]       = w_prod[k][PROD_W-1:DIV_K];
            w_rem_full[k] = w_u[k] - ((w_qt[k] << 2) + w_qt[k]);
            if (w_crd[k][S_W-1]) begin
                // less than one cell below zero still maps to cell 0
                w_low[k] = w_crd[k][11:0];
                w_out[k] = (w_crd[k] <= S_NEG_CELL);
                w_idx[k] = '0;
            end else begin
                w_low[k] = {1'b0, w_rem_full[k][2:0], w_crd[k][7:0]};
                w_out[k] = (w_qt[k] > U_W'(GRID_VERTS - 2));
                w_idx[k] = IDX_W'(w_qt[k]);
            end
        end
    end

    always_comb begin
        o_ent.is_load = r_load;
        o_ent.outside = !r_load && (w_out[0] || w_out[1]);
        o_ent.height  = r_height;
        o_ent.a       = {w_low[0][11], w_low[0]} - htq_pkg::A_W'(htq_pkg::CELL_Q);
        o_ent.b       = -w_low[1];
        o_col         = r_load ? IDX_W'(r_col_in) : w_idx[0];
        o_row         = r_load ? IDX_W'(r_row_in) : w_idx[1];
    end

endmodule

>>> src/htq_queue.sv
// htq_queue: small register FIFO between the front and back of the core.
// Depends on htq_pkg.
module htq_queue #(
    parameter int IDX_W = $clog2(htq_pkg::GRID_VERTS_DEF)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  htq_pkg::t_ent      i_ent,
    input  logic [IDX_W-1:0]   i_col,
    input  logic [IDX_W-1:0]   i_row,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_vld,
    output htq_pkg::t_ent      o_ent,
    output logic [IDX_W-1:0]   o_col,
    output logic [IDX_W-1:0]   o_row
);

    localparam int DEPTH = htq_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    htq_pkg::t_ent    r_ent [DEPTH];
    logic [IDX_W-1:0] r_col [DEPTH];
    logic [IDX_W-1:0] r_row [DEPTH];
    logic [PW-1:0]    r_wp;
    logic [PW-1:0]    r_rp;
    logic [CW-1:0]    r_cnt;
    logic [CW-1:0]    n_cnt;

    assign n_cnt  = r_cnt + CW'(i_push) - CW'(i_pop);
    assign o_full = (r_cnt == CW'(DEPTH));
    assign o_vld  = (r_cnt != '0);
    assign o_ent  = r_ent[r_rp];
    assign o_col  = r_col[r_rp];
    assign o_row  = r_row[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_ent;
            r_col[r_wp] <= i_col;
            r_row[r_wp] <= i_row;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt != CW'(DEPTH)))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_cnt != '0))
        else $error("queue pop while empty");
`endif

endmodule

>>> src/htq_back.sv
// htq_back: executes queued loads and queries. Holds the vertex heights in four
// parity banks, interpolates the triangle plane and drives the result channel.
// Depends on htq_pkg and htq_ram.
module htq_back #(
    parameter int GRID_VERTS = htq_pkg::GRID_VERTS_DEF,
    localparam int IDX_W = $clog2(GRID_VERTS)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_vld,
    output logic               o_q_pop,
    input  htq_pkg::t_ent      i_ent,
    input  logic [IDX_W-1:0]   i_col,
    input  logic [IDX_W-1:0]   i_row,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [15:0]        o_m_tdata,
    output logic               o_m_tuser
);

    localparam int HALF       = (GRID_VERTS + 1) / 2;
    localparam int BANK_DEPTH = HALF * HALF;
    localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int H_W        = htq_pkg::H_W;
    localparam int A_W        = htq_pkg::A_W;
    localparam int B_W        = htq_pkg::B_W;
    localparam int D_W        = htq_pkg::D_W;
    localparam int P_W        = htq_pkg::P_W;
    localparam int Y_W        = htq_pkg::Y_W;
    localparam int Q_W        = htq_pkg::Q_W;
    localparam int M_W        = Y_W + htq_pkg::DIV5_MUL_W;
    localparam int R_W        = Q_W + 2;
    // bank select masks relative to the corner vertex, {column, row}
    localparam logic [1:0] VX_RIGHT = 2'b10;
    localparam logic [1:0] VX_DOWN  = 2'b01;
    localparam logic [1:0] VX_DIAG  = 2'b11;

    logic                    w_adv;
    logic                    w_rd;
    logic                    w_wr;
    logic [IDX_W-1:0]        w_ch_e;
    logic [IDX_W-1:0]        w_ch_o;
    logic [IDX_W-1:0]        w_rh_e;
    logic [IDX_W-1:0]        w_rh_o;
    logic [AW-1:0]           w_raddr [4];
    logic [AW-1:0]           w_waddr;
    logic [1:0]              w_wbank;
    logic [H_W-1:0]          w_rdata [4];

    logic                    r_p1_vld, r_p2_vld, r_p3_vld, r_p4_vld, r_p5_vld, r_p6_vld;
    logic                    r_out_vld;

    logic                    r_p1_out;
    logic signed [A_W-1:0]   r_p1_a;
    logic signed [B_W-1:0]   r_p1_b;
    logic [1:0]              r_p1_par;

    logic signed [H_W-1:0]   w_h0, w_h1, w_h2, w_h3;
    logic                    w_upper;
    logic signed [D_W-1:0]   w_da, w_db;

    logic                    r_p2_out;
    logic signed [A_W-1:0]   r_p2_a;
    logic signed [B_W-1:0]   r_p2_b;
    logic signed [D_W-1:0]   r_p2_da, r_p2_db;
    logic signed [H_W-1:0]   r_p2_h1;

    logic                    r_p3_out;
    logic signed [P_W-1:0]   r_p3_pa, r_p3_pb;
    logic signed [H_W-1:0]   r_p3_h1;

    logic signed [P_W:0]     w_sum;
    logic [Y_W-1:0]          w_y;
    logic                    r_p4_out;
    logic [Y_W-1:0]          r_p4_y;
    logic signed [H_W-1:0]   r_p4_h1;

    logic [M_W-1:0]          w_qprod;
    logic                    r_p5_out;
    logic [Q_W-1:0]          r_p5_q0;
    logic [Y_W-1:0]          r_p5_y;
    logic signed [H_W-1:0]   r_p5_h1;

    logic [Y_W-1:0]          w_rem;
    logic                    w_inc;
    logic                    r_p6_out;
    logic signed [Q_W:0]     r_p6_q;
    logic signed [H_W-1:0]   r_p6_h1;

    logic signed [R_W-1:0]   w_res;
    logic                    w_fits;
    logic [H_W-1:0]          w_sat;
    logic [H_W-1:0]          r_out_height;
    logic                    r_out_outside;

    // whole back end moves together, held while the result register waits
    assign w_adv   = !r_out_vld || i_m_tready;
    assign o_q_pop = w_adv && i_q_vld;
    assign w_rd    = o_q_pop && !i_ent.is_load && !i_ent.outside;
    assign w_wr    = o_q_pop && i_ent.is_load;

    // the four cell corners always land in four different parity banks
    assign w_ch_o  = i_col >> 1;
    assign w_ch_e  = (i_col >> 1) + IDX_W'(i_col[0]);
    assign w_rh_o  = i_row >> 1;
    assign w_rh_e  = (i_row >> 1) + IDX_W'(i_row[0]);
    assign w_waddr = AW'(i_col >> 1) * AW'(HALF) + AW'(i_row >> 1);
    assign w_wbank = {i_col[0], i_row[0]};

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_raddr[k] = AW'(k[1] ? w_ch_o : w_ch_e) * AW'(HALF)
                       + AW'(k[0] ? w_rh_o : w_rh_e);
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_bank
        htq_ram #(
            .WIDTH (H_W),
            .DEPTH (BANK_DEPTH)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (w_wr && (w_wbank == 2'(g))),
            .i_waddr (w_waddr),
            .i_wdata (i_ent.height),
            .i_re    (w_rd),
            .i_raddr (w_raddr[g]),
            .o_rdata (w_rdata[g])
        );
    end

    // pick the triangle and its edge slopes along a and b
    assign w_h0    = w_rdata[r_p1_par];
    assign w_h1    = w_rdata[r_p1_par ^ VX_RIGHT];
    assign w_h2    = w_rdata[r_p1_par ^ VX_DOWN];
    assign w_h3    = w_rdata[r_p1_par ^ VX_DIAG];
    assign w_upper = $signed({r_p1_b[B_W-1], r_p1_b}) > r_p1_a;
    assign w_da    = w_upper ? (D_W'(w_h1) - D_W'(w_h0)) : (D_W'(w_h3) - D_W'(w_h2));
    assign w_db    = w_upper ? (D_W'(w_h0) - D_W'(w_h2)) : (D_W'(w_h1) - D_W'(w_h3));

    // round to nearest: floor((num + 640) / 256) then floor divide by five
    assign w_sum   = (P_W+1)'(r_p3_pa) + (P_W+1)'(r_p3_pb) + (P_W+1)'(htq_pkg::HALF_CELL_Q);
    assign w_y     = Y_W'($signed(w_sum[P_W:8])) + htq_pkg::Y_OFF;
    assign w_qprod = M_W'(r_p4_y) * M_W'(htq_pkg::DIV5_MUL);
    assign w_rem   = r_p5_y - ({r_p5_q0, 2'b00} + Y_W'(r_p5_q0));
    assign w_inc   = (w_rem >= htq_pkg::DIV5_MIN_REM);

    assign w_res   = R_W'(r_p6_q) + R_W'(r_p6_h1);
    assign w_fits  = (&w_res[R_W-1:H_W-1]) || !(|w_res[R_W-1:H_W-1]);
    assign w_sat   = w_fits ? w_res[H_W-1:0]
                   : (w_res[R_W-1] ? htq_pkg::SAT_MIN : htq_pkg::SAT_MAX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld  <= 1'b0;
            r_p2_vld  <= 1'b0;
            r_p3_vld  <= 1'b0;
            r_p4_vld  <= 1'b0;
            r_p5_vld  <= 1'b0;
            r_p6_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_p1_vld  <= o_q_pop && !i_ent.is_load;
            r_p2_vld  <= r_p1_vld;
            r_p3_vld  <= r_p2_vld;
            r_p4_vld  <= r_p3_vld;
            r_p5_vld  <= r_p4_vld;
            r_p6_vld  <= r_p5_vld;
            r_out_vld <= r_p6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p1_out <= i_ent.outside;
            r_p1_a   <= i_ent.a;
            r_p1_b   <= i_ent.b;
            r_p1_par <= {i_col[0], i_row[0]};

            r_p2_out <= r_p1_out;
            r_p2_a   <= r_p1_a;
            r_p2_b   <= r_p1_b;
            r_p2_da  <= w_da;
            r_p2_db  <= w_db;
            r_p2_h1  <= w_h1;

            r_p3_out <= r_p2_out;
            r_p3_pa  <= P_W'(r_p2_a) * P_W'(r_p2_da);
            r_p3_pb  <= P_W'(r_p2_b) * P_W'(r_p2_db);
            r_p3_h1  <= r_p2_h1;

            r_p4_out <= r_p3_out;
            r_p4_y   <= w_y;
            r_p4_h1  <= r_p3_h1;

            r_p5_out <= r_p4_out;
            r_p5_q0  <= w_qprod[htq_pkg::DIV5_SHIFT +: Q_W];
            r_p5_y   <= r_p4_y;
            r_p5_h1  <= r_p4_h1;

            r_p6_out <= r_p5_out;
            r_p6_q   <= (Q_W+1)'(r_p5_q0) + (Q_W+1)'(w_inc) - (Q_W+1)'(htq_pkg::Q_OFF);
            r_p6_h1  <= r_p5_h1;
        end
        if (w_adv && r_p6_vld) begin
            r_out_height  <= r_p6_out ? '0 : w_sat;
            r_out_outside <= r_p6_out;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_height;
    assign o_m_tuser  = r_out_outside;

`ifndef SYNTH
    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_outside) |-> (r_out_height == '0))
        else $error("outside result carries a nonzero height");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable({r_p1_vld, r_p2_vld, r_p3_vld, r_p4_vld, r_p5_vld, r_p6_vld}))
        else $error("pipeline moved during a stall");
`endif

endmodule

>>> src/heightfield_triangle_height_query_core.sv
// heightfield_triangle_height_query_core: top level of the heightfield height
// query core. Depends on htq_pkg, htq_front, htq_queue, htq_back and htq_ram.
//
// Usage:
//   The slave channel takes one item per transfer. tuser = 0 loads one vertex
//   height at (vert_col, vert_row); loads beyond the grid are dropped and no
//   load gives a result. tuser = 1 queries the surface height at (query_x,
//   query_z) and gives exactly one result transfer on the master channel.
//   Results come back in query order: tdata is the height in Q8.8, saturated,
//   and tuser flags a point outside the grid (height then zero).
//   A query passes the input register, the queue, stages p1 to p6 and the
//   result register. Throughput: one item per cycle while the master side is
//   ready; four single-port-read parity banks give the corner heights together.
//   A four-entry queue separates the input stage from the execution pipeline.
//   When the receiver stalls, the execution pipeline holds, the queue fills
//   and then the slave tready drops; no transfer is lost.
//   Reset clears the control state only; the stored heights are undefined
//   until loaded and every vertex a query touches must be loaded first.
module heightfield_triangle_height_query_core #(
    parameter int GRID_VERTS = htq_pkg::GRID_VERTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // vert_col[4:0], vert_row[9:5], vert_height[25:10], query_x[41:26],
    // query_z[57:42], zero fill[63:58]
    input  logic [63:0] i_s_tdata,
    // req_type
    input  logic        i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // surface_height[15:0]
    output logic [15:0] o_m_tdata,
    // outside_grid
    output logic        o_m_tuser
);

    localparam int IDX_W = $clog2(GRID_VERTS);

    logic               w_push;
    logic               w_full;
    logic               w_pop;
    logic               w_qvld;
    htq_pkg::t_ent      w_ent_in;
    htq_pkg::t_ent      w_ent_out;
    logic [IDX_W-1:0]   w_col_in;
    logic [IDX_W-1:0]   w_row_in;
    logic [IDX_W-1:0]   w_col_out;
    logic [IDX_W-1:0]   w_row_out;

    htq_front #(
        .GRID_VERTS (GRID_VERTS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_q_full   (w_full),
        .o_q_push   (w_push),
        .o_ent      (w_ent_in),
        .o_col      (w_col_in),
        .o_row      (w_row_in)
    );

    htq_queue #(
        .IDX_W (IDX_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_ent   (w_ent_in),
        .i_col   (w_col_in),
        .i_row   (w_row_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_vld   (w_qvld),
        .o_ent   (w_ent_out),
        .o_col   (w_col_out),
        .o_row   (w_row_out)
    );

    htq_back #(
        .GRID_VERTS (GRID_VERTS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_vld    (w_qvld),
        .o_q_pop    (w_pop),
        .i_ent      (w_ent_out),
        .i_col      (w_col_out),
        .i_row      (w_row_out),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// testbench: self-checking bench for heightfield_triangle_height_query_core.
// Fills the vertex grid, then runs directed and random loads and queries and
// checks each result against its own height predictor. Depends on htq_pkg.
module testbench;

    localparam int GRID_N         = htq_pkg::GRID_VERTS_DEF;
    localparam int CENTER         = (GRID_N - 1) / 2;
    localparam int H_W            = htq_pkg::H_W;
    localparam int CELL_Q         = htq_pkg::CELL_Q;
    localparam int HALF_CELL_Q    = htq_pkg::HALF_CELL_Q;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 24;
    localparam int HOLD_CYCLES    = 300;

    typedef struct packed {
        logic signed [H_W-1:0] height;
        logic                  outside;
    } t_surface_result;

    typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SPARSE} t_rx_mode;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [63:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [15:0] m_tdata;
    logic        m_tuser;

    // vertex heights as the block should hold them, [col][row]
    logic signed [H_W-1:0] vert_heights [GRID_N][GRID_N];
    t_surface_result       pending_heights[$];

    bit       gaps_on;
    int       burst_left;
    t_rx_mode rx_mode = RX_ALWAYS;
    int       hold_off_cycles;
    int       rx_phase;
    int       stuck_cycles;
    int       error_count;
    int       load_count, dropped_loads, query_count;
    int       outside_count, clipped_count, diagonal_count, input_stall_cycles;

    heightfield_triangle_height_query_core dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // plane height of the triangle under (qx, qz), rounded and clipped
    function automatic t_surface_result predict_surface(input logic signed [H_W-1:0] qx,
            input logic signed [H_W-1:0] qz, output bit on_diag);
        t_surface_result res;
        int s, t, col, row, a, b, h0, h1, h2, h3, num, q;
        s = CENTER * CELL_Q + qx;
        t = CENTER * CELL_Q - qz;
        col = s / CELL_Q;
        row = t / CELL_Q;
        on_diag = 1'b0;
        res.height = '0;
        res.outside = 1'b0;
        if (col < 0 || col > GRID_N - 2 || row < 0 || row > GRID_N - 2) begin
            res.outside = 1'b1;
        end else begin
            a = s - (col + 1) * CELL_Q;
            b = row * CELL_Q - t;
            h0 = vert_heights[col][row];
            h1 = vert_heights[col + 1][row];
            h2 = vert_heights[col][row + 1];
            h3 = vert_heights[col + 1][row + 1];
            on_diag = (a == b);
            if (b > a)
                num = a * (h1 - h0) + b * (h0 - h2);
            else
                num = a * (h3 - h2) + b * (h1 - h3);
            num = num + HALF_CELL_Q;
            q = num / CELL_Q;
            if (num % CELL_Q != 0 && num < 0)
                q = q - 1;
            q = q + h1;
            if (q > 32767)
                res.height = htq_pkg::SAT_MAX;
            else if (q < -32768)
                res.height = htq_pkg::SAT_MIN;
            else
                res.height = 16'(q);
        end
        return res;
    endfunction

    // one transfer on the slave side; bookkeeping happens on acceptance
    task automatic send_item(input logic req, input logic [4:0] col, input logic [4:0] row,
            input logic signed [H_W-1:0] hgt, input logic signed [H_W-1:0] qx,
            input logic signed [H_W-1:0] qz);
        t_surface_result res;
        bit              diag;
        int              gap;
        if (gaps_on && burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 25) : $urandom_range(1, 5);
            repeat (gap) begin
                @(negedge clk);
                s_tvalid <= 1'b0;
            end
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {6'b0, qz, qx, hgt, row, col};
        do @(posedge clk); while (!s_tready);
        if (burst_left > 0)
            burst_left--;
        if (req == htq_pkg::REQ_LOAD) begin
            load_count++;
            if (col < GRID_N && row < GRID_N)
                vert_heights[col][row] = hgt;
            else
                dropped_loads++;
        end else begin
            res = predict_surface(qx, qz, diag);
            pending_heights.push_back(res);
            query_count++;
            diagonal_count += int'(diag);
            if (res.outside)
                outside_count++;
            else if (res.height == htq_pkg::SAT_MAX || res.height == htq_pkg::SAT_MIN)
                clipped_count++;
        end
    endtask

    // unused fields carry random bits
    task automatic send_load(input logic [4:0] col, input logic [4:0] row,
            input logic signed [H_W-1:0] hgt);
        send_item(htq_pkg::REQ_LOAD, col, row, hgt, 16'($urandom), 16'($urandom));
    endtask

    task automatic send_query(input logic signed [H_W-1:0] qx, input logic signed [H_W-1:0] qz);
        send_item(htq_pkg::REQ_QUERY, 5'($urandom), 5'($urandom), 16'($urandom), qx, qz);
    endtask

    task automatic stop_sending;
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    function automatic logic signed [H_W-1:0] random_height;
        int v;
        if ($urandom_range(0, 3) == 0)
            v = int'($urandom);
        else
            v = int'($urandom_range(0, 4095)) - 2048;
        return 16'(v);
    endfunction

    // every vertex gets a height so that no query reads an unloaded entry
    task automatic test_fill_grid;
        gaps_on = 1'b1;
        rx_mode = RX_RANDOM;
        for (int c = 0; c < GRID_N; c++)
            for (int r = 0; r < GRID_N; r++)
                send_load(5'(c), 5'(r), random_height());
        stop_sending();
    endtask

    task automatic test_directed;
        gaps_on = 1'b0;
        rx_mode = RX_ALWAYS;
        // steep cell at the low x edge, extrapolated beyond it: clips low, then high
        send_load(5'd0, 5'd0, htq_pkg::SAT_MIN);
        send_load(5'd1, 5'd0, htq_pkg::SAT_MAX);
        send_load(5'd0, 5'd1, 16'sd0);
        send_load(5'd1, 5'd1, 16'sd0);
        send_query(-16'sd14079, 16'sd12800);
        send_query(-16'sd14079, 16'sd14079);
        send_load(5'd1, 5'd0, htq_pkg::SAT_MIN);
        send_load(5'd0, 5'd0, htq_pkg::SAT_MAX);
        send_query(-16'sd14079, 16'sd12800);
        // point on the cell diagonal
        send_query(-16'sd640, 16'sd640);
        // just outside or just inside the grid edges, then the extreme coordinates
        send_query(-16'sd14080, 16'sd0);
        send_query(16'sd12800, 16'sd0);
        send_query(16'sd0, 16'sd14080);
        send_query(16'sd0, 16'sd12801);
        send_query(16'sd12799, -16'sd12799);
        send_query(htq_pkg::SAT_MIN, htq_pkg::SAT_MIN);
        send_query(htq_pkg::SAT_MAX, htq_pkg::SAT_MAX);
        // loads beyond the grid must not land anywhere
        send_load(5'd31, 5'd5, htq_pkg::SAT_MAX);
        send_load(5'd5, 5'd31, htq_pkg::SAT_MIN);
        send_load(5'd21, 5'd20, 16'sd1234);
        send_load(5'd20, 5'd21, -16'sd1234);
        send_query(16'sd12799, -16'sd12799);
        send_load(5'd20, 5'd20, htq_pkg::SAT_MAX);
        send_query(16'sd12799, -16'sd12799);
        stop_sending();
    endtask

    task automatic test_random_traffic(input int n_items, input bit with_gaps,
            input t_rx_mode mode);
        int qx, qz;
        gaps_on = with_gaps;
        rx_mode = mode;
        burst_left = 0;
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 99) < 35) begin
                if ($urandom_range(0, 9) == 0)
                    send_load(5'($urandom), 5'($urandom), random_height());
                else
                    send_load(5'($urandom_range(0, GRID_N - 1)),
                              5'($urandom_range(0, GRID_N - 1)), random_height());
            end else begin
                case ($urandom_range(0, 9))
                    0: begin
                        qx = int'($urandom);
                        qz = int'($urandom);
                    end
                    1, 2: begin
                        // on vertices, edges and diagonals
                        qx = int'($urandom_range(0, GRID_N)) * CELL_Q - CENTER * CELL_Q;
                        qx = qx + (($urandom_range(0, 2) == 0) ? 0 : HALF_CELL_Q);
                        qz = CENTER * CELL_Q - int'($urandom_range(0, GRID_N)) * CELL_Q;
                        qz = qz - (($urandom_range(0, 2) == 0) ? 0 : HALF_CELL_Q);
                    end
                    default: begin
                        // whole grid plus the extrapolated strip below cell 0
                        qx = int'($urandom_range(0, 26878)) - 14079;
                        qz = 14079 - int'($urandom_range(0, 26878));
                    end
                endcase
                send_query(16'(qx), 16'(qz));
            end
        end
        stop_sending();
    endtask

    // receiver holds off while queries keep coming, so the block must stall its input
    task automatic test_backpressure;
        gaps_on = 1'b0;
        rx_mode = RX_ALWAYS;
        hold_off_cycles = HOLD_CYCLES;
        for (int i = 0; i < 40; i++)
            send_query(16'(int'($urandom_range(0, 25599)) - 12800),
                       16'(12800 - int'($urandom_range(0, 25599))));
        stop_sending();
    endtask

    always begin
        @(negedge clk);
        if (hold_off_cycles > 0) begin
            m_tready <= 1'b0;
            hold_off_cycles--;
        end else begin
            rx_phase = (rx_phase + 1) % 11;
            case (rx_mode)
                RX_ALWAYS:  m_tready <= 1'b1;
                RX_RANDOM:  m_tready <= ($urandom_range(0, 1) == 1);
                RX_PATTERN: m_tready <= (rx_phase < 7);
                default:    m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge clk) begin : result_check
        t_surface_result want;
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_heights.size() == 0) begin
                $error("surface_height: unexpected transfer, expected none, actual %0d",
                       $signed(m_tdata));
                error_count++;
            end else begin
                want = pending_heights.pop_front();
                if (m_tdata !== want.height) begin
                    $error("surface_height: expected %0d, actual %0d",
                           want.height, $signed(m_tdata));
                    error_count++;
                end
                if (m_tuser !== want.outside) begin
                    $error("outside_grid: expected %0d, actual %0d", want.outside, m_tuser);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (s_tvalid && !s_tready)
            input_stall_cycles++;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("heightfield_triangle_height_query_core test failed");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_fill_grid();
        test_directed();
        test_random_traffic(180, 1'b1, RX_RANDOM);
        test_backpressure();
        test_random_traffic(160, 1'b0, RX_ALWAYS);
        test_random_traffic(160, 1'b1, RX_PATTERN);
        test_random_traffic(140, 1'b1, RX_SPARSE);
        while (pending_heights.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("run covered %0d loads (%0d off the grid) and %0d queries", load_count,
                 dropped_loads, query_count);
        $display("  %0d outside, %0d clipped, %0d on a diagonal, %0d input stall cycles",
                 outside_count, clipped_count, diagonal_count, input_stall_cycles);
        if (error_count == 0)
            $display("heightfield_triangle_height_query_core test passed");
        else
            $display("heightfield_triangle_height_query_core test failed");
        $finish;
    end

endmodule

>>> sim.f
src/htq_pkg.sv
src/htq_ram.sv
src/htq_front.sv
src/htq_queue.sv
src/htq_back.sv
src/heightfield_triangle_height_query_core.sv
test/testbench.sv
